/* hw/rtl/irpd_pkg.sv */
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types, register indexes, reset values and the window test of the
// pulse-distance infrared decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

   localparam int DUR_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CODE_OUT_W  = 64;
   localparam int COUNT_W     = 8;
   localparam int CODE_WIDTH_DEF = 64;

   localparam logic [DUR_W-1:0] HEADER_MARK_RST  = 16'd9000;
   localparam logic [DUR_W-1:0] HEADER_SPACE_RST = 16'd4500;
   localparam logic [DUR_W-1:0] BIT_MARK_RST     = 16'd560;
   localparam logic [DUR_W-1:0] ONE_SPACE_RST    = 16'd1690;
   localparam logic [DUR_W-1:0] ZERO_SPACE_RST   = 16'd560;
   localparam logic [DUR_W-1:0] TOLERANCE_RST    = 16'd100;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_MARK  = 3'd0,
      CSR_HEADER_SPACE = 3'd1,
      CSR_BIT_MARK     = 3'd2,
      CSR_ONE_SPACE    = 3'd3,
      CSR_ZERO_SPACE   = 3'd4,
      CSR_TOLERANCE    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_HEADER  = 3'd0,
      KIND_ONE     = 3'd1,
      KIND_ZERO    = 3'd2,
      KIND_INVALID = 3'd3,
      KIND_END     = 3'd4
   } kind_type;

   typedef struct packed {
      logic [DUR_W-1:0] header_mark_us;
      logic [DUR_W-1:0] header_space_us;
      logic [DUR_W-1:0] bit_mark_us;
      logic [DUR_W-1:0] one_space_us;
      logic [DUR_W-1:0] zero_space_us;
      logic [DUR_W-1:0] tolerance_us;
   } cfg_type;

   // strict window (n - t) < v < (n + t), done as unsigned sums to avoid signs
   function automatic logic in_window(logic [DUR_W-1:0] v, logic [DUR_W-1:0] n,
                                      logic [DUR_W-1:0] t);
      logic [DUR_W:0] v_plus_t;
      logic [DUR_W:0] n_plus_t;
      v_plus_t = {1'b0, v} + {1'b0, t};
      n_plus_t = {1'b0, n} + {1'b0, t};
      return (v_plus_t > {1'b0, n}) && ({1'b0, v} < n_plus_t);
   endfunction

endpackage

/* hw/rtl/irpd_if.sv */
// ----------------------------------------------------------------------------
// irpd_req_if / irpd_rsp_if
// Valid/ready channels of the decoder: duration pairs in, classified pairs out.
// ----------------------------------------------------------------------------
interface irpd_req_if;
   import irpd_pkg::*;
   logic             valid;
   logic             ready;
   logic [DUR_W-1:0] mark_us;
   logic [DUR_W-1:0] space_us;

   modport source (output valid, output mark_us, output space_us, input ready);
   modport sink   (input valid, input mark_us, input space_us, output ready);
endinterface

interface irpd_rsp_if;
   import irpd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [2:0]            pair_kind;
   logic [CODE_OUT_W-1:0] code_bits;
   logic [COUNT_W-1:0]    bit_total;
   logic                  any_invalid;
   logic                  frame_done;

   modport source (output valid, output pair_kind, output code_bits, output bit_total,
                   output any_invalid, output frame_done, input ready);
   modport sink   (input valid, input pair_kind, input code_bits, input bit_total,
                   input any_invalid, input frame_done, output ready);
endinterface

/* hw/rtl/irpd_csr.sv */
// ----------------------------------------------------------------------------
// irpd_csr
// Timing registers of the decoder, written through a plain write port.
// ----------------------------------------------------------------------------
module irpd_csr import irpd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]       csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEADER_MARK:  cfg_in.header_mark_us  = csr_wdata;
            CSR_HEADER_SPACE: cfg_in.header_space_us = csr_wdata;
            CSR_BIT_MARK:     cfg_in.bit_mark_us     = csr_wdata;
            CSR_ONE_SPACE:    cfg_in.one_space_us    = csr_wdata;
            CSR_ZERO_SPACE:   cfg_in.zero_space_us   = csr_wdata;
            CSR_TOLERANCE:    cfg_in.tolerance_us    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mark_us  <= HEADER_MARK_RST;
         cfg_ff.header_space_us <= HEADER_SPACE_RST;
         cfg_ff.bit_mark_us     <= BIT_MARK_RST;
         cfg_ff.one_space_us    <= ONE_SPACE_RST;
         cfg_ff.zero_space_us   <= ZERO_SPACE_RST;
         cfg_ff.tolerance_us    <= TOLERANCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/irpd_classify.sv */
// ----------------------------------------------------------------------------
// irpd_classify
// Window tests on one registered mark/space pair, giving the pair kind.
// ----------------------------------------------------------------------------
module irpd_classify import irpd_pkg::*; (
   input  cfg_type          cfg,
   input  logic [DUR_W-1:0] mark_us,
   input  logic [DUR_W-1:0] space_us,
   output kind_type         kind
);

   logic mark_ok;
   logic hdr_ok;
   logic one_ok;
   logic zero_ok;

   always_comb begin
      mark_ok = in_window(mark_us, cfg.bit_mark_us, cfg.tolerance_us);
      hdr_ok  = in_window(mark_us, cfg.header_mark_us, cfg.tolerance_us) &&
                in_window(space_us, cfg.header_space_us, cfg.tolerance_us);
      one_ok  = in_window(space_us, cfg.one_space_us, cfg.tolerance_us);
      zero_ok = in_window(space_us, cfg.zero_space_us, cfg.tolerance_us);

      // header beats frame end, frame end beats a data bit, one beats zero
      if (hdr_ok) begin
         kind = KIND_HEADER;
      end else if (mark_ok && (space_us == '0)) begin
         kind = KIND_END;
      end else if (one_ok) begin
         kind = mark_ok ? KIND_ONE : KIND_INVALID;
      end else if (zero_ok) begin
         kind = mark_ok ? KIND_ZERO : KIND_INVALID;
      end else begin
         kind = KIND_INVALID;
      end
   end

endmodule

/* hw/rtl/irpd_frame.sv */
// ----------------------------------------------------------------------------
// irpd_frame
// Frame state (code shift register, bit count, invalid flag) and the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
module irpd_frame import irpd_pkg::*; #(
   parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  kind_type   kind,
   output logic       stage_ready,
   irpd_rsp_if.source rsp_chan
);

   logic [CODE_WIDTH-1:0] code_ff, code_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  inval_ff, inval_in;

   logic                  out_valid_ff;
   kind_type              out_kind_ff;
   logic [CODE_WIDTH-1:0] out_code_ff;
   logic [COUNT_W-1:0]    out_count_ff;
   logic                  out_inval_ff;

   always_comb begin
      code_in  = code_ff;
      count_in = count_ff;
      inval_in = inval_ff;
      case (kind)
         KIND_HEADER: begin
            code_in  = '0;
            count_in = '0;
            inval_in = 1'b0;
         end
         KIND_END: ;
         default: begin
            code_in = {code_ff[CODE_WIDTH-2:0], (kind == KIND_ONE)};
            if (count_ff != {COUNT_W{1'b1}}) begin
               count_in = count_ff + 1'b1;
            end
            if (kind == KIND_INVALID) begin
               inval_in = 1'b1;
            end
         end
      endcase
   end

   assign stage_ready = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff      <= '0;
         count_ff     <= '0;
         inval_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            code_ff      <= code_in;
            count_ff     <= count_in;
            inval_ff     <= inval_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_kind_ff  <= kind;
         out_code_ff  <= code_in;
         out_count_ff <= count_in;
         out_inval_ff <= inval_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pair_kind   = out_kind_ff;
   assign rsp_chan.code_bits   = CODE_OUT_W'(out_code_ff);
   assign rsp_chan.bit_total   = out_count_ff;
   assign rsp_chan.any_invalid = out_inval_ff;
   assign rsp_chan.frame_done  = (out_kind_ff == KIND_END);

endmodule

/* hw/rtl/ir_pulse_distance_decoder.sv */
// ----------------------------------------------------------------------------
// ir_pulse_distance_decoder
// Classifies infrared mark/space duration pairs and assembles the frame code.
// ----------------------------------------------------------------------------
// Use:
//   req_chan carries one measured mark/space pair in microseconds per item.
//   rsp_chan returns one item per pair: the pair kind, the code bits decoded
//   so far (earliest bit most significant), the bit count since the last
//   header, the sticky invalid flag and a frame-done strobe.
//   csr_* writes the six timing registers; write only while no item is in
//   flight.
// Pipeline: an accepted pair passes the input register, then the window tests
//   and state update into the result register.
// Throughput: one item per cycle while rsp_chan does not stall; the frame state
//   feeds back on itself with no extra stage, so back-to-back pairs are taken without a gap.
// Reset: timing registers take their nominal values, code, count and flag
//   clear, both stages empty.
// Stall: while rsp_chan.ready is low the result holds; one more item waits in
//   the input register, after which req_chan.ready drops.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder import irpd_pkg::*; #(
   parameter int CODE_WIDTH = CODE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DUR_W-1:0]       csr_wdata,
   irpd_req_if.sink               req_chan,
   irpd_rsp_if.source             rsp_chan
);

   cfg_type          cfg;
   kind_type         kind;
   logic             stage_ready;
   logic             take;

   logic             in_valid_ff;
   logic [DUR_W-1:0] in_mark_ff;
   logic [DUR_W-1:0] in_space_ff;

   irpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign take           = in_valid_ff && stage_ready;
   assign req_chan.ready = !in_valid_ff || stage_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_mark_ff  <= req_chan.mark_us;
         in_space_ff <= req_chan.space_us;
      end
   end

   irpd_classify u_classify (
      .cfg      (cfg),
      .mark_us  (in_mark_ff),
      .space_us (in_space_ff),
      .kind     (kind)
   );

   irpd_frame #(
      .CODE_WIDTH (CODE_WIDTH)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .kind        (kind),
      .stage_ready (stage_ready),
      .rsp_chan    (rsp_chan)
   );

endmodule
